[rtl/core/f4m_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package f4m_pkg;

  // widths of the datapath
  localparam int SYM_W        = 12;  // scaled symbol, signed
  localparam int TAP_W        = 16;  // shaping coefficient, signed
  localparam int ACC_W        = 29;  // partial sum, holds 167021 * 1362 with sign
  localparam int SAMP_W       = 16;  // output sample
  localparam int SYM_PER_BYTE = 4;
  localparam int SCNT_W       = 2;   // symbol counter within a byte
  localparam int SHAPE_LEN    = 45;

  localparam logic signed [TAP_W-1:0] SHAPE_TAPS [SHAPE_LEN] = '{
    16'sd0,     16'sd0,     16'sd0,     16'sd0,     16'sd0,
    16'sd0,     16'sd0,     16'sd0,     16'sd0,     16'sd0,
    16'sd0,     16'sd0,     16'sd0,     16'sd0,     16'sd0,
    16'sd0,     16'sd17,    16'sd319,   16'sd2659,  16'sd10668,
    16'sd22736, 16'sd30728, 16'sd32767, 16'sd30728, 16'sd22736,
    16'sd10668, 16'sd2659,  16'sd319,   16'sd17,    16'sd0,
    16'sd0,     16'sd0,     16'sd0,     16'sd0,     16'sd0,
    16'sd0,     16'sd0,     16'sd0,     16'sd0,     16'sd0,
    16'sd0,     16'sd0,     16'sd0,     16'sd0,     16'sd0
  };

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_RUN  = 3'b100
  } state_e;

  // coefficient lookup, taps past the table read as zero
  function automatic logic signed [TAP_W-1:0] tap_at(input int unsigned idx);
    logic [5:0] sel;
    sel = idx[5:0];
    if (idx < SHAPE_LEN) begin
      return SHAPE_TAPS[sel];
    end
    return '0;
  endfunction

  // saturate the shifted sum to a 16-bit sample
  function automatic logic [SAMP_W-1:0] sat16(input logic signed [ACC_W-16:0] v);
    if (int'(v) > 32767) begin
      return 16'h7fff;
    end
    if (int'(v) < -32768) begin
      return 16'h8000;
    end
    return SAMP_W'(v);
  endfunction

endpackage

`default_nettype wire

[rtl/core/f4m_symbol_map.sv]
`timescale 1ns / 1ps
`default_nettype none

module f4m_symbol_map
  import f4m_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire logic                    silent_i,
  input  wire logic [1:0]              dibit_i,
  input  wire logic [7:0]              tx_level_i,
  output logic signed [SYM_W-1:0]      sym_o
);

  logic signed [SYM_W-1:0] level;
  logic signed [20:0]      prod;
  logic signed [SYM_W-1:0] sym_d, sym_q;

  always_comb begin
    case (dibit_i)
      2'b11:   level = 12'sd1362;
      2'b10:   level = 12'sd454;
      2'b00:   level = -12'sd454;
      default: level = -12'sd1362;
    endcase
  end

  // level * tx_level * 128 >> 15 is level * tx_level >> 8, always within 12 bits
  assign prod  = level * $signed({1'b0, tx_level_i});
  assign sym_d = silent_i ? '0 : prod[8 +: SYM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= '0;
    end else if (load_i) begin
      sym_q <= sym_d;
    end
  end

  assign sym_o = sym_q;

endmodule

`default_nettype wire

[rtl/core/f4m_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module f4m_cell
  import f4m_pkg::*;
#(
  parameter int INTERP_FACTOR = 5,
  parameter int CELL_IDX      = 0,
  parameter int PH_W          = 3
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic [PH_W-1:0]         phase_i,
  input  wire logic signed [SYM_W-1:0] sym_i,
  input  wire logic signed [ACC_W-1:0] psum_i,
  output logic signed [ACC_W-1:0]      head_o,
  output logic signed [ACC_W-1:0]      next_o
);

  // one partial sum per phase, rotating so that the head is the current phase
  logic signed [ACC_W-1:0]       part_q [INTERP_FACTOR];
  logic signed [TAP_W-1:0]       coef;
  logic signed [SYM_W+TAP_W-1:0] prod;

  assign coef   = tap_at(32'(INTERP_FACTOR * CELL_IDX) + 32'(phase_i));
  assign prod   = sym_i * coef;
  assign next_o = ACC_W'(prod) + psum_i;
  assign head_o = part_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < INTERP_FACTOR; i++) begin
        part_q[i] <= '0;
      end
    end else if (en_i) begin
      for (int i = 0; i < INTERP_FACTOR - 1; i++) begin
        part_q[i] <= part_q[i+1];
      end
      part_q[INTERP_FACTOR-1] <= next_o;
    end
  end

endmodule

`default_nettype wire

[rtl/core/fsk4_symbol_mapper_pulse_shaper.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  transfer contents
// s_axis    in         tdata = data_byte[7:0], tuser = op (1 = silence)
// m_axis    out        tdata = sample[15:0] signed, tlast = twentieth sample
// cfg       in         data = tx_level[7:0], always ready
//
// an item passes through an accept in idle, a symbol load, then the run state:
// one sample per cycle from the cell chain while the output is not stalled
// each output sample is one phase update of the cell row
// reset clears the sequencer, the symbol register and every partial sum in the row
// a stalled output holds the whole row until the sample register is free

module fsk4_symbol_mapper_pulse_shaper
  import f4m_pkg::*;
#(
  parameter int INTERP_FACTOR  = 5,
  parameter int TAPS_PER_PHASE = 9
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [7:0]  s_tdata_i,    // [7:0] data_byte
  input  wire logic        s_tuser_i,    // [0] op
  // output stream
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [15:0]      m_tdata_o,    // [15:0] sample
  output logic             m_tlast_o,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i
);

  localparam int PH_W = (INTERP_FACTOR > 1) ? $clog2(INTERP_FACTOR) : 1;
  localparam logic [PH_W-1:0]   PH_LAST  = PH_W'(INTERP_FACTOR - 1);
  localparam logic [SCNT_W-1:0] SYM_LAST = SCNT_W'(SYM_PER_BYTE - 1);

  // configuration register
  logic [7:0] tx_level_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_level_q <= 8'd128;
    end else if (cfg_valid_i) begin
      tx_level_q <= cfg_data_i;
    end
  end

  // sequencer
  state_e            state_q, state_d;
  logic [SCNT_W-1:0] sym_cnt_q, sym_cnt_d;
  logic [PH_W-1:0]   phase_q, phase_d;
  logic              op_q;
  logic [7:0]        byte_q;
  logic              adv;
  logic              map_load;
  logic [SCNT_W-1:0] map_idx;
  logic [1:0]        dibit;

  // one phase step when the sample register is free or drains this cycle
  assign adv        = (state_q == ST_RUN) && (!m_tvalid_o || m_tready_i);
  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    sym_cnt_d = sym_cnt_q;
    phase_d   = phase_q;
    map_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          state_d   = ST_LOAD;
          sym_cnt_d = '0;
          phase_d   = '0;
        end
      end
      ST_LOAD: begin
        map_load = 1'b1;
        state_d  = ST_RUN;
      end
      ST_RUN: begin
        if (adv) begin
          if (phase_q == PH_LAST) begin
            phase_d = '0;
            if (sym_cnt_q == SYM_LAST) begin
              state_d = ST_IDLE;
            end else begin
              // next symbol enters while the row takes the last phase of this one
              sym_cnt_d = sym_cnt_q + 1'b1;
              map_load  = 1'b1;
            end
          end else begin
            phase_d = phase_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sym_cnt_q <= '0;
      phase_q   <= '0;
    end else begin
      state_q   <= state_d;
      sym_cnt_q <= sym_cnt_d;
      phase_q   <= phase_d;
    end
  end

  // item payload, taken on the input transfer
  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      op_q   <= s_tuser_i;
      byte_q <= s_tdata_i;
    end
  end

  // msb dibit first
  assign map_idx = (state_q == ST_LOAD) ? sym_cnt_q : sym_cnt_q + 1'b1;
  assign dibit   = 2'(byte_q >> {~map_idx, 1'b0});

  logic signed [SYM_W-1:0] sym;

  f4m_symbol_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (map_load),
    .silent_i   (op_q),
    .dibit_i    (dibit),
    .tx_level_i (tx_level_q),
    .sym_o      (sym)
  );

  // transposed polyphase row: cell k adds h[I*k+j]*x to the partial sum of cell k+1
  logic signed [ACC_W-1:0] head [TAPS_PER_PHASE];
  logic signed [ACC_W-1:0] next [TAPS_PER_PHASE];

  for (genvar k = 0; k < TAPS_PER_PHASE; k++) begin : g_cell
    logic signed [ACC_W-1:0] nbr;
    if (k == TAPS_PER_PHASE - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = head[k+1];
    end

    f4m_cell #(
      .INTERP_FACTOR (INTERP_FACTOR),
      .CELL_IDX      (k),
      .PH_W          (PH_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .phase_i (phase_q),
      .sym_i   (sym),
      .psum_i  (nbr),
      .head_o  (head[k]),
      .next_o  (next[k])
    );
  end

  // output register, the first cell gives the finished sum
  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic        out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= sat16(next[0][ACC_W-1:15]);
      out_last_q <= (sym_cnt_q == SYM_LAST) && (phase_q == PH_LAST);
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

  // checks
  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (state_q == ST_LOAD))
    else $error("accepted item did not start a symbol load");

  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q <= PH_LAST))
    else $error("phase counter out of range");

  a_last_ends_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (sym_cnt_q == SYM_LAST) && (phase_q == PH_LAST))
      |=> (state_q == ST_IDLE) && m_tvalid_o && m_tlast_o)
    else $error("final sample not flagged or item not closed");

  a_load_from_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> $past(state_q == ST_LOAD || state_q == ST_RUN))
    else $error("run entered without a symbol load");

endmodule

`default_nettype wire
